// ----- design/fsp_pkg.sv -----
// Shared types, codes and character decode for the format specifier parser.
package fsp_pkg;

    // Per-word result status
    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_INVALID  = 2'd2
    } status_t;

    // Parse phase; the order matters, phases only move forward
    typedef enum logic [1:0] {
        PH_FLAGS = 2'd0,
        PH_WIDTH = 2'd1,
        PH_PREC  = 2'd2,
        PH_CONV  = 2'd3
    } phase_t;

    // Conversion codes
    localparam logic [3:0] CONV_NONE    = 4'd0;
    localparam logic [3:0] CONV_CHAR    = 4'd1;
    localparam logic [3:0] CONV_STRING  = 4'd2;
    localparam logic [3:0] CONV_POINTER = 4'd3;
    localparam logic [3:0] CONV_DEC_D   = 4'd4;
    localparam logic [3:0] CONV_DEC_I   = 4'd5;
    localparam logic [3:0] CONV_UNSIGN  = 4'd6;
    localparam logic [3:0] CONV_HEX_LO  = 4'd7;
    localparam logic [3:0] CONV_HEX_UP  = 4'd8;
    localparam logic [3:0] CONV_PERCENT = 4'd9;

    // Flag bit positions
    localparam int FLAG_ZERO      = 0;
    localparam int FLAG_MINUS     = 1;
    localparam int FLAG_PLUS      = 2;
    localparam int FLAG_SPACE     = 3;
    localparam int FLAG_ALTERNATE = 4;
    localparam int NUM_FLAGS      = 5;

    localparam logic [15:0] ACC_MAX = 16'hFFFF;

    // Complete parser state
    typedef struct packed {
        phase_t                 phase;
        logic [NUM_FLAGS-1:0]   flags;
        logic [15:0]            width;
        logic [15:0]            prec;
        logic [3:0]             conv;
    } parse_state_t;

    // One-hot flag for a flag character, zero otherwise
    function automatic logic [NUM_FLAGS-1:0] flag_onehot(input logic [7:0] ch);
        logic [NUM_FLAGS-1:0] fl;
        fl = '0;
        unique case (ch)
            8'h30:   fl[FLAG_ZERO]      = 1'b1;
            8'h2D:   fl[FLAG_MINUS]     = 1'b1;
            8'h2B:   fl[FLAG_PLUS]      = 1'b1;
            8'h20:   fl[FLAG_SPACE]     = 1'b1;
            8'h23:   fl[FLAG_ALTERNATE] = 1'b1;
            default: fl = '0;
        endcase
        return fl;
    endfunction

    // Conversion code for a conversion letter, CONV_NONE otherwise
    function automatic logic [3:0] conv_code(input logic [7:0] ch);
        logic [3:0] cv;
        unique case (ch)
            8'h63:   cv = CONV_CHAR;
            8'h73:   cv = CONV_STRING;
            8'h70:   cv = CONV_POINTER;
            8'h64:   cv = CONV_DEC_D;
            8'h69:   cv = CONV_DEC_I;
            8'h75:   cv = CONV_UNSIGN;
            8'h78:   cv = CONV_HEX_LO;
            8'h58:   cv = CONV_HEX_UP;
            8'h25:   cv = CONV_PERCENT;
            default: cv = CONV_NONE;
        endcase
        return cv;
    endfunction

endpackage

// ----- design/fsp_step.sv -----
// Next-state and status logic for one format string word.
module fsp_step (
    input  fsp_pkg::parse_state_t cur_state,
    input  logic                  start_new,
    input  logic [7:0]            character,
    output fsp_pkg::parse_state_t next_state,
    output fsp_pkg::status_t      status
);
    import fsp_pkg::*;

    parse_state_t         base;
    logic [NUM_FLAGS-1:0] fl;
    logic [3:0]           cv;
    logic                 is_digit;
    logic                 is_dot;
    logic                 known;
    phase_t               target;
    logic                 bad;
    logic [15:0]          acc_in;
    logic [19:0]          acc_sum;
    logic [15:0]          acc_sat;

    // Decode the character
    always_comb begin
        base     = start_new ? '0 : cur_state;
        fl       = flag_onehot(character);
        cv       = conv_code(character);
        is_digit = (character >= 8'h30) && (character <= 8'h39);
        is_dot   = (character == 8'h2E);
    end

    // Classify into a target phase, earliest match wins
    always_comb begin
        known  = 1'b1;
        target = PH_FLAGS;
        priority if (base.phase == PH_FLAGS && (|fl)) begin
            target = PH_FLAGS;
        end else if ((base.phase == PH_PREC && is_digit) ||
                     (base.phase != PH_PREC && is_dot)) begin
            target = PH_PREC;
        end else if (is_digit) begin
            target = PH_WIDTH;
        end else if (cv != CONV_NONE) begin
            target = PH_CONV;
        end else begin
            known = 1'b0;
        end
    end

    // Shared times-ten accumulate with saturation
    always_comb begin
        acc_in  = (target == PH_WIDTH) ? base.width : base.prec;
        acc_sum = ({4'b0, acc_in} << 3) + ({4'b0, acc_in} << 1) + {16'b0, character[3:0]};
        acc_sat = (acc_sum > {4'b0, ACC_MAX}) ? ACC_MAX : acc_sum[15:0];
    end

    // Apply the word or drop it as invalid
    always_comb begin
        bad = !known || (target < base.phase) ||
              (target == PH_FLAGS && (|(fl & base.flags)));
        next_state = base;
        status     = ST_INVALID;
        if (!bad) begin
            next_state.phase = target;
            unique case (target)
                PH_FLAGS: next_state.flags = base.flags | fl;
                PH_WIDTH: next_state.width = acc_sat;
                PH_PREC:  next_state.prec  = is_dot ? base.prec : acc_sat;
                PH_CONV:  next_state.conv  = cv;
                default:  next_state = base;
            endcase
            status = (target == PH_CONV) ? ST_COMPLETE : ST_CONTINUE;
        end
    end

endmodule

// ----- design/format_specifier_parser.sv -----
// Top level: printf conversion specification parser, one word per cycle while m_ready drains results.
// A word captured at acceptance goes to the input register, then to the state/result register once that slot is free.
// Throughput: 1 word per cycle unless a result stalls; the state update is one decode plus one times-ten add.
// The parser state registers double as the result payload, so they hold while a result stalls.
// Reset: synchronous active-low aresetn clears parser state and both valid flags.
// Set s_start_new on the first character after a percent sign to restart the parse.
module format_specifier_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_new,
    input  logic [7:0]  s_character,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_phase,
    output logic        m_flag_zero,
    output logic        m_flag_minus,
    output logic        m_flag_plus,
    output logic        m_flag_space,
    output logic        m_flag_alternate,
    output logic [15:0] m_field_width,
    output logic [15:0] m_precision_value,
    output logic [3:0]  m_conversion
);
    import fsp_pkg::*;

    logic         in_valid_reg;
    logic         in_start_reg;
    logic [7:0]   in_char_reg;
    logic         out_valid_reg;
    status_t      status_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    status_t      status_next;
    logic         advance;

    // Move a word into the result slot when it is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    fsp_step u_step (
        .cur_state  (state_reg),
        .start_new  (in_start_reg),
        .character  (in_char_reg),
        .next_state (state_next),
        .status     (status_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_start_reg <= s_start_new;
            in_char_reg  <= s_character;
        end
    end

    // Parser state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            status_reg    <= ST_CONTINUE;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                status_reg    <= status_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Drive result ports
    assign m_valid           = out_valid_reg;
    assign m_status          = status_reg;
    assign m_phase           = state_reg.phase;
    assign m_flag_zero       = state_reg.flags[FLAG_ZERO];
    assign m_flag_minus      = state_reg.flags[FLAG_MINUS];
    assign m_flag_plus       = state_reg.flags[FLAG_PLUS];
    assign m_flag_space      = state_reg.flags[FLAG_SPACE];
    assign m_flag_alternate  = state_reg.flags[FLAG_ALTERNATE];
    assign m_field_width     = state_reg.width;
    assign m_precision_value = state_reg.prec;
    assign m_conversion      = state_reg.conv;

    // A completed word always leaves a conversion in place
    a_complete_has_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && status_reg == ST_COMPLETE) |->
            (state_reg.phase == PH_CONV && state_reg.conv != CONV_NONE))
        else $error("complete status without conversion");

    // An invalid word without restart leaves the state untouched
    a_invalid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_start_reg && status_next == ST_INVALID) |=>
            (state_reg == $past(state_reg)))
        else $error("invalid word changed parser state");

    // Nothing past the flags is set while still in the flag phase
    a_flag_phase_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_FLAGS) |->
            (state_reg.width == '0 && state_reg.prec == '0 && state_reg.conv == CONV_NONE))
        else $error("flag phase with later fields set");

    // Precision stays clear before the precision phase
    a_prec_before_dot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_FLAGS || state_reg.phase == PH_WIDTH) |->
            (state_reg.prec == '0))
        else $error("precision set before dot");

endmodule
